// File: rtl/binary_to_decimal_ascii_defines.svh
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii assertion macros
// Concurrent assertion forms for the decimal converter RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication
`define B2DA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b2da assertion failed");

// next-cycle implication
`define B2DA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b2da assertion failed");

`endif

// File: rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Constants and helpers for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int MAX_DIGITS_DEF = 10;

   localparam int DIGIT_BITS = 4;
   localparam int ASCII_BITS = 6;
   localparam int STEP_BITS  = 4;   // double-dabble shifts per stage

   localparam logic [ASCII_BITS-1:0] ASCII_ZERO   = 6'd48;
   localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_BITS-1:0] DABBLE_ADJ   = 4'd3;

   // decimal digits of 2**n - 1 (1233/4096 ~ log10(2))
   function automatic int bcd_digits(input int n);
      return ((n * 1233) >> 12) + 1;
   endfunction

endpackage

// File: rtl/b2da_if.sv
// ----------------------------------------------------------------------------
// b2da channel interfaces
// Valid/ready channels for the request value and the digit response.
// ----------------------------------------------------------------------------
interface b2da_req_if #(
   parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface b2da_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [b2da_pkg::ASCII_BITS-1:0]    ascii_digit;
   logic                               last_digit;

   modport source (output valid, output ascii_digit, output last_digit, input ready);
   modport sink   (input valid, input ascii_digit, input last_digit, output ready);
endinterface

// File: rtl/b2da_stage.sv
// ----------------------------------------------------------------------------
// b2da_stage
// One pipeline stage of the double-dabble conversion, STEP_BITS shifts.
// ----------------------------------------------------------------------------
module b2da_stage #(
   parameter int DIGITS   = 11,
   parameter int BIN_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic [DIGITS*b2da_pkg::DIGIT_BITS-1:0]   in_bcd,
   input  logic [BIN_BITS-1:0]                      in_bin,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic [DIGITS*b2da_pkg::DIGIT_BITS-1:0]   out_bcd,
   output logic [BIN_BITS-1:0]                      out_bin
);

   localparam int DB = b2da_pkg::DIGIT_BITS;

   logic                   valid_ff;
   logic [DIGITS*DB-1:0]   bcd_ff;
   logic [DIGITS*DB-1:0]   bcd_in;
   logic [BIN_BITS-1:0]    bin_ff;
   logic [BIN_BITS-1:0]    bin_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_bcd   = bcd_ff;
   assign out_bin   = bin_ff;

   always_comb begin
      bcd_in = in_bcd;
      bin_in = in_bin;
      for (int s = 0; s < b2da_pkg::STEP_BITS; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (bcd_in[d*DB +: DB] >= b2da_pkg::DABBLE_LIMIT) begin
               bcd_in[d*DB +: DB] = bcd_in[d*DB +: DB] + b2da_pkg::DABBLE_ADJ;
            end
         end
         {bcd_in, bin_in} = {bcd_in, bin_in} << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         bcd_ff <= bcd_in;
         bin_ff <= bin_in;
      end
   end

endmodule

// File: rtl/b2da_serial.sv
// ----------------------------------------------------------------------------
// b2da_serial
// Digit serializer: emits BCD digits as ASCII, most significant first.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_defines.svh"

module b2da_serial #(
   parameter int WORK_DIGITS = 11,
   parameter int MAX_DIGITS  = 10
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         in_valid,
   output logic                                         in_ready,
   input  logic [WORK_DIGITS*b2da_pkg::DIGIT_BITS-1:0]  in_bcd,
   b2da_rsp_if.source                                   rsp_bus
);

   localparam int DB    = b2da_pkg::DIGIT_BITS;
   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(MAX_DIGITS - 1);

   logic             busy_ff;
   logic [IDX_W-1:0] pos_ff;
   logic [IDX_W-1:0] pos_in;
   logic [IDX_W-1:0] lead_idx;
   logic [DB-1:0]    dig_ff [MAX_DIGITS];
   logic [DB-1:0]    cur_digit;
   logic             overflow;
   logic             fire_out;
   logic             done;
   logic             load;

   // keep the MAX_DIGITS low digits; anything above forces a full-width run
   assign overflow = |in_bcd[WORK_DIGITS*DB-1 : MAX_DIGITS*DB];

   always_comb begin
      lead_idx = '0;
      for (int k = 0; k < MAX_DIGITS; k++) begin
         if (in_bcd[k*DB +: DB] != '0) begin
            lead_idx = IDX_W'(k);
         end
      end
      pos_in = overflow ? TOP_IDX : lead_idx;
   end

   assign cur_digit = dig_ff[pos_ff];
   assign fire_out  = busy_ff && rsp_bus.ready;
   assign done      = fire_out && (pos_ff == '0);
   assign in_ready  = !busy_ff || done;
   assign load      = in_valid && in_ready;

   assign rsp_bus.valid       = busy_ff;
   assign rsp_bus.ascii_digit = b2da_pkg::ASCII_ZERO
                              + {{(b2da_pkg::ASCII_BITS-DB){1'b0}}, cur_digit};
   assign rsp_bus.last_digit  = (pos_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         pos_ff  <= pos_in;
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (fire_out) begin
         pos_ff  <= pos_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < MAX_DIGITS; k++) begin
            dig_ff[k] <= in_bcd[k*DB +: DB];
         end
      end
   end

   `B2DA_ASSERT_NEXT(a_hold_on_stall, clock, reset, busy_ff && !rsp_bus.ready, busy_ff && $stable(pos_ff))
   `B2DA_ASSERT_NEXT(a_step_down, clock, reset, fire_out && (pos_ff != '0), busy_ff && (pos_ff == $past(pos_ff) - 1'b1))
   `B2DA_ASSERT_NOW(a_take_on_last, clock, reset, busy_ff && in_ready, rsp_bus.last_digit && rsp_bus.ready)
   `B2DA_ASSERT_NOW(a_pos_range, clock, reset, busy_ff, pos_ff <= TOP_IDX)

endmodule

// File: rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned binary to decimal ASCII digit stream, leading zeros suppressed.
// ----------------------------------------------------------------------------
//  channel   dir  payload                      handshake
//  req_bus   in   value[VALUE_BITS]            valid/ready
//  rsp_bus   out  ascii_digit[6], last_digit   valid/ready
//
//  Pipeline: ceil(VALUE_BITS/4) double-dabble stages, 4 shifts each, then the
//  serializer, which registers the digits before the first one is sent.
//  Throughput: one digit per cycle while rsp ready is high; a value sends d
//  digits (1..MAX_DIGITS) and the next loads as its last digit goes out.
//  Reset: synchronous; clears stage valid bits and the serializer busy flag.
//  Stalls: rsp ready low holds the current digit; the stages fill and req
//  ready drops, nothing is lost or repeated.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
   parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   b2da_req_if.sink    req_bus,
   b2da_rsp_if.source  rsp_bus
);

   localparam int DB          = b2da_pkg::DIGIT_BITS;
   localparam int STEP        = b2da_pkg::STEP_BITS;
   localparam int BCD_DIGITS  = b2da_pkg::bcd_digits(VALUE_BITS);
   localparam int WORK_DIGITS = ((BCD_DIGITS > MAX_DIGITS) ? BCD_DIGITS : MAX_DIGITS) + 1;
   localparam int STAGES      = (VALUE_BITS + STEP - 1) / STEP;
   localparam int PAD_BITS    = STAGES * STEP;

   logic                      valid_w [STAGES+1];
   logic                      ready_w [STAGES+1];
   logic [WORK_DIGITS*DB-1:0] bcd_w   [STAGES+1];
   logic [PAD_BITS-1:0]       bin_w   [STAGES+1];

   assign valid_w[0]    = req_bus.valid;
   assign req_bus.ready = ready_w[0];
   assign bcd_w[0]      = '0;
   assign bin_w[0]      = PAD_BITS'(req_bus.value);

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      b2da_stage #(
         .DIGITS   (WORK_DIGITS),
         .BIN_BITS (PAD_BITS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[i]),
         .in_ready  (ready_w[i]),
         .in_bcd    (bcd_w[i]),
         .in_bin    (bin_w[i]),
         .out_valid (valid_w[i+1]),
         .out_ready (ready_w[i+1]),
         .out_bcd   (bcd_w[i+1]),
         .out_bin   (bin_w[i+1])
      );
   end

   b2da_serial #(
      .WORK_DIGITS (WORK_DIGITS),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_serial (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_w[STAGES]),
      .in_ready (ready_w[STAGES]),
      .in_bcd   (bcd_w[STAGES]),
      .rsp_bus  (rsp_bus)
   );

endmodule

// File: sim/binary_to_decimal_ascii_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_tb
// Drives 32-bit values into the converter and checks every ASCII digit and
// last-digit flag against a decimal expansion computed in the bench.
// Covers directed edge values, random values of every magnitude, random
// idling on both channels, a long response hold-off and back-to-back traffic.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_tb;

   localparam int VALUE_BITS   = b2da_pkg::VALUE_BITS_DEF;
   localparam int MAX_DIGITS   = b2da_pkg::MAX_DIGITS_DEF;
   localparam int RADIX        = 10;
   localparam int WATCHDOG_MAX = 2000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 64;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [b2da_pkg::ASCII_BITS-1:0] ascii_digit;
      logic                            last_digit;
   } digit_type;

   logic clock;
   logic reset;

   b2da_req_if #(.VALUE_BITS(VALUE_BITS)) req_bus ();
   b2da_rsp_if                            rsp_bus ();

   binary_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_DIGITS(MAX_DIGITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   digit_type pending_digits[$];
   int     mismatches     = 0;
   int     values_sent    = 0;
   int     digits_checked = 0;
   int     stuck_cycles   = 0;
   bit     req_idling     = 1'b1;
   bit     rsp_idling     = 1'b1;
   bit     hold_off_req   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // decimal expansion, most significant digit first
   function automatic void expand_decimal(input logic [VALUE_BITS-1:0] value);
      logic [3:0]            digit_buf [MAX_DIGITS];
      logic [VALUE_BITS-1:0] rest;
      int                    count;
      digit_type             d;
      rest  = value;
      count = 0;
      if (rest == '0) begin
         d.ascii_digit = b2da_pkg::ASCII_ZERO;
         d.last_digit  = 1'b1;
         pending_digits.push_back(d);
         return;
      end
      while (rest != '0 && count < MAX_DIGITS) begin
         digit_buf[count] = 4'(rest % RADIX);
         rest             = rest / RADIX;
         count++;
      end
      for (int k = count - 1; k >= 0; k--) begin
         d.ascii_digit = b2da_pkg::ASCII_ZERO + b2da_pkg::ASCII_BITS'(digit_buf[k]);
         d.last_digit  = (k == 0);
         pending_digits.push_back(d);
      end
   endfunction

   task automatic send_value(input logic [VALUE_BITS-1:0] value);
      if (req_idling && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      expand_decimal(value);
      values_sent++;
   endtask

   // response side: ready with random hold bursts, plus one long hold on request
   initial begin
      int n;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            n = HOLD_CYCLES;
         end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            n = $urandom_range(1, 13);
         end else begin
            rsp_bus.ready <= 1'b1;
            n = $urandom_range(1, 8);
         end
         repeat (n) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      digit_type got;
      digit_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.ascii_digit = rsp_bus.ascii_digit;
         got.last_digit  = rsp_bus.last_digit;
         if (pending_digits.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%t unexpected digit: ascii_digit=%0d last_digit=%0d",
                        $realtime, got.ascii_digit, got.last_digit);
         end else begin
            want = pending_digits.pop_front();
            digits_checked++;
            if (got.ascii_digit !== want.ascii_digit || got.last_digit !== want.last_digit) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%t mismatch: ascii_digit exp %0d got %0d, last_digit exp %0d got %0d",
                           $realtime, want.ascii_digit, got.ascii_digit,
                           want.last_digit, got.last_digit);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_MAX) begin
         $display("timeout: no item moved for %0d cycles", stuck_cycles);
         $display("FAIL binary_to_decimal_ascii");
         $finish;
      end
   end

   task automatic test_edge_values();
      logic [VALUE_BITS-1:0] vals [$];
      vals = {32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101, 32'd65535,
              32'd999999999, 32'd1000000000, 32'd1234567890, 32'd2147483647,
              32'd2147483648, 32'd4000000000, 32'd4294967294, 32'd4294967295,
              32'h5555_5555, 32'hAAAA_AAAA, 32'd0, 32'd7};
      foreach (vals[i])
         send_value(vals[i]);
   endtask

   task automatic test_random_values(input int count);
      logic [VALUE_BITS-1:0] v;
      logic [VALUE_BITS-1:0] pow10;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom >> $urandom_range(0, 31);
            2: begin
               pow10 = 1;
               repeat ($urandom_range(0, 9)) pow10 = pow10 * RADIX;
               v = pow10 - $urandom_range(0, 1);
            end
            default: v = $urandom_range(0, 999);
         endcase
         send_value(v);
      end
   endtask

   task automatic test_response_hold(input int count);
      req_idling   = 1'b0;
      hold_off_req = 1'b1;
      for (int i = 0; i < count; i++)
         send_value($urandom);
      req_idling = 1'b1;
   endtask

   task automatic test_back_to_back(input int count);
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      for (int i = 0; i < count; i++)
         send_value($urandom >> $urandom_range(0, 31));
   endtask

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_values();
      test_random_values(290);
      test_response_hold(40);
      test_back_to_back(80);

      req_bus.valid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("converted %0d values to %0d checked digits; edge values, random magnitudes,",
               values_sent, digits_checked);
      $display("random idling, a %0d-cycle response hold and back-to-back traffic; %0d mismatches",
               HOLD_CYCLES, mismatches);
      if (mismatches == 0 && pending_digits.size() == 0) begin
         $display("PASS binary_to_decimal_ascii");
      end else begin
         $display("FAIL binary_to_decimal_ascii");
      end
      $finish;
   end

endmodule

// File: binary_to_decimal_ascii.f
+incdir+rtl
rtl/b2da_pkg.sv
rtl/b2da_if.sv
rtl/b2da_stage.sv
rtl/b2da_serial.sv
rtl/binary_to_decimal_ascii.sv
sim/binary_to_decimal_ascii_tb.sv
